[rtl/lebd_pkg.sv]
// lebd_pkg: shared types and constants for the leb128 decoder
// used by lebd_core and leb128_variable_length_decoder, no dependencies
package lebd_pkg;

    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned SHIFT_W  = 7;
    localparam int unsigned COUNT_W  = 4;

    localparam logic [SHIFT_W-1:0] SHIFT_STEP = 7'd7;
    localparam logic [SHIFT_W-1:0] SHIFT_SAT  = 7'd70;
    localparam logic [SHIFT_W-1:0] SHIFT_LAST = 7'd63;
    localparam logic [SHIFT_W-1:0] SHIFT_TOP  = 7'd64;
    localparam logic [COUNT_W-1:0] COUNT_SAT  = 4'd15;
    localparam logic [VALUE_W-1:0] ALL_ONES   = '1;

    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
        logic               error;
        logic [COUNT_W-1:0] byte_count;
    } result_t;

endpackage

[rtl/lebd_core.sv]
// lebd_core: decode state registers and the per-byte gather and finish logic
// depends on lebd_pkg
module lebd_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic              signed_mode,
    input  logic              final_available,
    output lebd_pkg::result_t result
);

    logic [lebd_pkg::VALUE_W-1:0] acc_reg, acc_next;
    logic [lebd_pkg::SHIFT_W-1:0] shift_reg, shift_next;
    logic [lebd_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                         mode_reg, mode_next;
    logic                         in_value_reg, in_value_next;

    logic                         first;
    logic [lebd_pkg::VALUE_W-1:0] acc;
    logic [lebd_pkg::SHIFT_W-1:0] shift;
    logic [lebd_pkg::COUNT_W-1:0] count;
    logic                         mode;
    logic                         cont;
    logic [lebd_pkg::VALUE_W-1:0] slice;
    logic [lebd_pkg::VALUE_W-1:0] gathered;
    logic [lebd_pkg::SHIFT_W-1:0] shift_sum;
    logic [lebd_pkg::SHIFT_W-1:0] shift_new;
    logic [5:0]                   sign_idx;
    logic [lebd_pkg::VALUE_W-1:0] sext_val;
    logic                         done;

    always_comb
    begin
        first = !in_value_reg;
        acc   = first ? '0 : acc_reg;
        shift = first ? '0 : shift_reg;
        count = first ? '0 : count_reg;
        mode  = first ? signed_mode : mode_reg;
        cont  = data_byte[7];

        if (count < lebd_pkg::COUNT_SAT)
        begin
            count = count + 4'd1;
        end

        if (shift < lebd_pkg::SHIFT_TOP)
        begin
            slice = {57'd0, data_byte[6:0]} << shift[5:0];
        end
        else
        begin
            slice = '0;
        end
        gathered  = acc | slice;
        shift_sum = shift + lebd_pkg::SHIFT_STEP;
        shift_new = (shift_sum > lebd_pkg::SHIFT_SAT) ? lebd_pkg::SHIFT_SAT : shift_sum;

        // sign bit sits just below the new shift
        sign_idx = shift_new[5:0] - 6'd1;
        sext_val = gathered;
        if (shift_new < lebd_pkg::SHIFT_TOP && gathered[sign_idx])
        begin
            sext_val = gathered | (lebd_pkg::ALL_ONES << shift_new[5:0]);
        end

        result.valid      = 1'b0;
        result.value      = gathered;
        result.error      = 1'b0;
        result.byte_count = count;

        if (!mode)
        begin
            if (shift > lebd_pkg::SHIFT_LAST)
            begin
                // eleventh byte overflows
                result.valid = 1'b1;
                result.value = lebd_pkg::ALL_ONES;
                result.error = 1'b1;
            end
            else if (!cont)
            begin
                result.valid = 1'b1;
            end
            else if (final_available)
            begin
                result.valid = 1'b1;
                result.value = lebd_pkg::ALL_ONES;
                result.error = 1'b1;
            end
        end
        else if (!cont || final_available)
        begin
            result.valid = 1'b1;
            result.value = sext_val;
            result.error = cont;
        end

        done = result.valid;

        acc_next      = acc_reg;
        shift_next    = shift_reg;
        count_next    = count_reg;
        mode_next     = mode_reg;
        in_value_next = in_value_reg;
        if (accept)
        begin
            if (done)
            begin
                acc_next      = '0;
                shift_next    = '0;
                count_next    = '0;
                mode_next     = 1'b0;
                in_value_next = 1'b0;
            end
            else
            begin
                acc_next      = gathered;
                shift_next    = shift_new;
                count_next    = count;
                mode_next     = mode;
                in_value_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            shift_reg    <= '0;
            count_reg    <= '0;
            mode_reg     <= 1'b0;
            in_value_reg <= 1'b0;
        end
        else
        begin
            acc_reg      <= acc_next;
            shift_reg    <= shift_next;
            count_reg    <= count_next;
            mode_reg     <= mode_next;
            in_value_reg <= in_value_next;
        end
    end

endmodule

[rtl/leb128_variable_length_decoder.sv]
// leb128 decoder: one encoded byte per transaction, one result per finished value
// output: results register in out_reg, or in the skid register under out_stall
// throughput: one byte per cycle unless in_stall, set by the gather in lebd_core;
// a skid register keeps input flowing while one result waits on out_stall
// reset: asynchronous active-low rst_n clears decode state and empties outputs
// depends on lebd_pkg and lebd_core
module leb128_variable_length_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        signed_mode,
    input  logic        final_available,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] value,
    output logic        error,
    output logic [3:0]  byte_count
);

    lebd_pkg::result_t res;
    lebd_pkg::result_t out_reg, out_next;
    lebd_pkg::result_t skid_reg, skid_next;
    logic              accept;
    logic              push;
    logic              out_free;

    assign in_stall = skid_reg.valid;
    assign accept   = in_valid && !in_stall;
    assign push     = accept && res.valid;

    lebd_core u_core
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .data_byte       (data_byte),
        .signed_mode     (signed_mode),
        .final_available (final_available),
        .result          (res)
    );

    always_comb
    begin
        out_free  = !out_reg.valid || !out_stall;
        out_next  = out_reg;
        skid_next = skid_reg;
        if (out_free)
        begin
            if (skid_reg.valid)
            begin
                // skid drains first; no new transaction was taken this cycle
                out_next        = skid_reg;
                skid_next.valid = 1'b0;
            end
            else if (push)
            begin
                out_next = res;
            end
            else
            begin
                out_next.valid = 1'b0;
            end
        end
        else if (push)
        begin
            skid_next = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg  <= '0;
            skid_reg <= '0;
        end
        else
        begin
            out_reg  <= out_next;
            skid_reg <= skid_next;
        end
    end

    assign out_valid  = out_reg.valid;
    assign value      = out_reg.value;
    assign error      = out_reg.error;
    assign byte_count = out_reg.byte_count;

endmodule
